// File: rtl/core/sts_pkg.sv
// Shared types and codes for the session table with aging.
package sts_pkg;

    localparam int SLOT_W  = 3;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int TIMER_W = 8;
    localparam int MODE_W  = 3;
    localparam int KIND_W  = 2;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd10;

    localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_JOIN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUIT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHAT = 3'd3;

    localparam logic [KIND_W-1:0] KIND_USER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JOIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHAT = 2'd3;

    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
        logic [TIMER_W-1:0] timer;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] dest_slot;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
        logic [SLOT_W-1:0] subject_slot;
        logic              subject_known;
    } result_t;

endpackage

// File: rtl/core/session_table_with_aging.sv
// Session table of MAX_SLOTS client slots with timer aging: one request in, a burst of notices out.
//
// Each input request (s_axis) is an event: tick, join/stay, quit or chat. The block first scans
// all slots out of a single slot RAM ({address, port, timer} per slot) to find the matching slot,
// and on a tick it ages every used slot in the same pass, writing back the decremented timer and
// marking slots whose timer is already zero. It then produces its notices on m_axis in the order
// of the slot index within each fan-out, with m_axis_tlast set on the final notice of the event;
// events that cause no notice produce nothing. An event passes through the idle state that takes
// the request, the scan and the wrap-up; each user-data notice takes an emit, each other notice a
// RAM read and an emit, each fan-out a closing step (the user-data run of a join counts as one),
// a tick a step of its own plus one per expiring slot, and the output side can stall any of them.
// Only one event is in work at a time: s_axis_tready is high while no event is in work, and a
// finished notice may still wait in the output register while the next event is taken. The used
// flags live in flip-flops that reset clears; the slot RAM needs no clearing, since the data of an
// entry counts only while its slot is used. timeout_ticks is written through cfg_wr_en/cfg_wr_data
// and must only change while the block is idle.
module session_table_with_aging
    import sts_pkg::*;
#(
    parameter int MAX_SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: timeout_ticks
    input  logic               cfg_wr_en,
    input  logic [TIMER_W-1:0] cfg_wr_data,
    // event requests
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [63:0]        s_axis_tdata,   // [31:0] src_ip, [47:32] src_port, [63:48] join_port
    input  logic [MODE_W-1:0]  s_axis_tuser,   // [2:0] mode
    // notices
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [55:0]        m_axis_tdata,   // [2:0] dest_slot, [34:3] dest_ip, [50:35] dest_port,
                                               // [53:51] subject_slot, [55:54] zero
    output logic [2:0]         m_axis_tuser,   // [1:0] kind, [2] subject_known
    output logic               m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_SCAN_END  = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_TICK_NEXT = 4'd4;
    localparam logic [3:0] S_USER      = 4'd5;
    localparam logic [3:0] S_FAN_RD    = 4'd6;
    localparam logic [3:0] S_FAN_EM    = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    // Lowest set bit of a slot mask.
    function automatic logic [IDX_W-1:0] low_idx(input logic [MAX_SLOTS-1:0] m);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (m[k]) begin
                r = IDX_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [MAX_SLOTS-1:0] slot_bit(input logic [IDX_W-1:0] i);
        return MAX_SLOTS'(1) << i;
    endfunction

    // control state
    logic [3:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 chk_reg, chk_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [MAX_SLOTS-1:0] used_reg, used_next;
    logic [MAX_SLOTS-1:0] expire_reg, expire_next;
    logic [MAX_SLOTS-1:0] mask_reg, mask_next;
    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TIMER_W-1:0]   timeout_reg;

    // payload state
    logic [MODE_W-1:0]    mode_reg;
    logic [IP_W-1:0]      ip_reg;
    logic [PORT_W-1:0]    sport_reg;
    logic [PORT_W-1:0]    jport_reg;
    logic [IDX_W-1:0]     sub_reg, sub_next;
    logic                 known_reg, known_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 drop_reg, drop_next;
    logic [IDX_W-1:0]     new_reg, new_next;
    logic [IDX_W-1:0]     dest_reg, dest_next;
    result_t              pend_reg, pend_next;
    result_t              m_res_reg, m_res_next;
    logic                 m_last_reg, m_last_next;

    // slot RAM
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t               rd_entry;

    logic                 out_free;
    logic                 can_emit;
    logic                 emit;
    result_t              emit_res;
    logic                 accept;
    logic                 chk_match;
    logic [IDX_W-1:0]     pick;

    sts_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry      = entry_t'(ram_rdata);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A notice goes to the staging register first; it moves on to the output register only once
    // the next notice (or the end of the event) tells whether it is the last one.
    assign out_free = !m_valid_reg || m_axis_tready;
    assign can_emit = !pend_valid_reg || out_free;

    assign chk_match = used_reg[chk_idx_reg] && (rd_entry.ip == ip_reg)
                       && (rd_entry.port == sport_reg);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        chk_next        = 1'b0;
        chk_idx_next    = idx_reg;
        used_next       = used_reg;
        expire_next     = expire_reg;
        mask_next       = mask_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        sub_next        = sub_reg;
        known_next      = known_reg;
        kind_next       = kind_reg;
        drop_next       = drop_reg;
        new_next        = new_reg;
        dest_next       = dest_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = rd_entry;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        emit            = 1'b0;
        emit_res        = '0;
        pick            = '0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;

        // Check the entry read in the previous scan cycle: age it on a tick, match it otherwise.
        // Writes land on the entry behind the one being read, so the two never collide.
        if (chk_reg) begin
            if (mode_reg == MODE_TICK) begin
                if (used_reg[chk_idx_reg]) begin
                    if (rd_entry.timer == '0) begin
                        expire_next[chk_idx_reg] = 1'b1;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata.timer = rd_entry.timer - TIMER_W'(1);
                    end
                end
            end else if (chk_match && !hit_found_reg) begin
                hit_found_next = 1'b1;
                hit_idx_next   = chk_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next       = '0;
                    hit_found_next = 1'b0;
                    hit_idx_next   = '0;
                    expire_next    = '0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN: begin
                ram_re       = 1'b1;
                ram_raddr    = idx_reg;
                chk_next     = 1'b1;
                chk_idx_next = idx_reg;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_SCAN_END;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SCAN_END: begin
                state_next = S_DECIDE;
            end

            S_DECIDE: begin
                state_next = S_FINISH;
                if (mode_reg == MODE_TICK) begin
                    state_next = S_TICK_NEXT;
                end else if (mode_reg == MODE_JOIN) begin
                    if (hit_found_reg) begin
                        // stay: reload the timer, address and port are unchanged by the match
                        ram_we          = 1'b1;
                        ram_waddr       = hit_idx_reg;
                        ram_wdata.ip    = ip_reg;
                        ram_wdata.port  = sport_reg;
                        ram_wdata.timer = timeout_reg;
                    end else if (~used_reg != '0) begin
                        pick            = low_idx(~used_reg);
                        ram_we          = 1'b1;
                        ram_waddr       = pick;
                        ram_wdata.ip    = ip_reg;
                        ram_wdata.port  = jport_reg;
                        ram_wdata.timer = timeout_reg;
                        used_next       = used_reg | slot_bit(pick);
                        new_next        = pick;
                        mask_next       = used_reg | slot_bit(pick);
                        state_next      = S_USER;
                    end
                end else if (mode_reg == MODE_QUIT) begin
                    if (hit_found_reg) begin
                        mask_next  = used_reg & ~slot_bit(hit_idx_reg);
                        kind_next  = KIND_QUIT;
                        sub_next   = hit_idx_reg;
                        known_next = 1'b1;
                        drop_next  = 1'b1;
                        state_next = S_FAN_RD;
                    end
                end else if (mode_reg == MODE_CHAT) begin
                    mask_next  = used_reg;
                    kind_next  = KIND_CHAT;
                    sub_next   = hit_found_reg ? hit_idx_reg : '0;
                    known_next = hit_found_reg;
                    drop_next  = 1'b0;
                    state_next = S_FAN_RD;
                end
            end

            S_TICK_NEXT: begin
                // expire slots in ascending order; earlier ones are already freed
                if (expire_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    pick        = low_idx(expire_reg);
                    expire_next = expire_reg & ~slot_bit(pick);
                    mask_next   = used_reg & ~slot_bit(pick);
                    kind_next   = KIND_QUIT;
                    sub_next    = pick;
                    known_next  = 1'b1;
                    drop_next   = 1'b1;
                    state_next  = S_FAN_RD;
                end
            end

            S_USER: begin
                if (mask_reg == '0) begin
                    mask_next  = used_reg & ~slot_bit(new_reg);
                    kind_next  = KIND_JOIN;
                    sub_next   = new_reg;
                    known_next = 1'b1;
                    drop_next  = 1'b0;
                    state_next = S_FAN_RD;
                end else if (can_emit) begin
                    pick                   = low_idx(mask_reg);
                    mask_next              = mask_reg & ~slot_bit(pick);
                    emit                   = 1'b1;
                    emit_res.kind          = KIND_USER;
                    emit_res.dest_slot     = SLOT_W'(new_reg);
                    emit_res.dest_ip       = ip_reg;
                    emit_res.dest_port     = jport_reg;
                    emit_res.subject_slot  = SLOT_W'(pick);
                    emit_res.subject_known = 1'b1;
                end
            end

            S_FAN_RD: begin
                if (mask_reg == '0) begin
                    if (drop_reg) begin
                        used_next = used_reg & ~slot_bit(sub_reg);
                    end
                    state_next = (mode_reg == MODE_TICK) ? S_TICK_NEXT : S_FINISH;
                end else begin
                    pick       = low_idx(mask_reg);
                    ram_re     = 1'b1;
                    ram_raddr  = pick;
                    dest_next  = pick;
                    mask_next  = mask_reg & ~slot_bit(pick);
                    state_next = S_FAN_EM;
                end
            end

            S_FAN_EM: begin
                // read data holds while no new read is issued
                if (can_emit) begin
                    emit                   = 1'b1;
                    emit_res.kind          = kind_reg;
                    emit_res.dest_slot     = SLOT_W'(dest_reg);
                    emit_res.dest_ip       = rd_entry.ip;
                    emit_res.dest_port     = rd_entry.port;
                    emit_res.subject_slot  = SLOT_W'(sub_reg);
                    emit_res.subject_known = known_reg;
                    state_next             = S_FAN_RD;
                end
            end

            S_FINISH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // output side: drain, then load from staging
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_res_next   = pend_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end else if (state_reg == S_FINISH && pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_res_next      = pend_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            used_reg       <= '0;
            expire_reg     <= '0;
            mask_reg       <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            chk_reg        <= chk_next;
            chk_idx_reg    <= chk_idx_next;
            used_reg       <= used_next;
            expire_reg     <= expire_next;
            mask_reg       <= mask_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // hold the request fields for the whole event
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_axis_tuser;
            ip_reg    <= s_axis_tdata[31:0];
            sport_reg <= s_axis_tdata[47:32];
            jport_reg <= s_axis_tdata[63:48];
        end
        sub_reg    <= sub_next;
        known_reg  <= known_next;
        kind_reg   <= kind_next;
        drop_reg   <= drop_next;
        new_reg    <= new_next;
        dest_reg   <= dest_next;
        pend_reg   <= pend_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {2'b00, m_res_reg.subject_slot, m_res_reg.dest_port,
                            m_res_reg.dest_ip, m_res_reg.dest_slot};
    assign m_axis_tuser  = {m_res_reg.subject_known, m_res_reg.kind};

endmodule

// File: rtl/core/sts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the session table with aging: directed and random event streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sts_pkg::*;

    localparam int NSLOTS         = 8;
    localparam int NPEERS         = 12;    // more peers than slots, so the table fills up
    localparam int SETTLE_CYCLES  = 32;    // scan and wrap-up of an event that emits nothing
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 38;    // split in two halves with a full drain between

    // Modes with no meaning; the block must swallow them.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] jport;
    } request_t;

    typedef struct packed {
        result_t body;
        logic    last;
    } notice_t;

    // DUT ports
    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [TIMER_W-1:0] cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata;   // [31:0] src_ip, [47:32] src_port, [63:48] join_port
    logic [MODE_W-1:0]  s_axis_tuser;   // [2:0] mode
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [55:0]        m_axis_tdata;   // [2:0] dest_slot, [34:3] dest_ip, [50:35] dest_port,
                                        // [53:51] subject_slot, [55:54] zero
    logic [2:0]         m_axis_tuser;   // [1:0] kind, [2] subject_known
    logic               m_axis_tlast;

    // Stimulus side
    request_t request_q[$];             // requests waiting for the driver
    int       src_idle_pct;
    int       snk_idle_pct;
    logic [IP_W-1:0]   peer_ip   [NPEERS];
    logic [PORT_W-1:0] peer_port [NPEERS];

    // Session table as the testbench expects it
    logic [TIMER_W-1:0] timeout_shadow;
    bit                 tbl_used  [NSLOTS];
    logic [IP_W-1:0]    tbl_ip    [NSLOTS];
    logic [PORT_W-1:0]  tbl_port  [NSLOTS];
    logic [TIMER_W-1:0] tbl_timer [NSLOTS];
    notice_t            burst[$];       // notices of the event being predicted
    notice_t            notices_q[$];   // notices still owed by the DUT, oldest first
    int                 errors;

    int phase_src_idle [RANDOM_PHASES] = '{0, 54, 0, 8, 0};
    int phase_snk_idle [RANDOM_PHASES] = '{0, 0, 54, 8, 0};
    logic [TIMER_W-1:0] phase_timeout [RANDOM_PHASES] = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd5};

    session_table_with_aging #(
        .MAX_SLOTS(NSLOTS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run.
    initial begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // Append one notice addressed to slot dest; the address and port come from the table.
    task automatic add_notice(input logic [KIND_W-1:0] kind, input int dest, input int subj,
                              input bit known);
        notice_t n;
        n.body.kind          = kind;
        n.body.dest_slot     = dest[SLOT_W-1:0];
        n.body.dest_ip       = tbl_ip[dest];
        n.body.dest_port     = tbl_port[dest];
        n.body.subject_slot  = known ? subj[SLOT_W-1:0] : '0;
        n.body.subject_known = known;
        n.last               = 1'b0;
        burst.push_back(n);
    endtask

    // Fan a notice out to every used slot in index order, skipping slot skip (-1 skips none).
    task automatic notify_used(input logic [KIND_W-1:0] kind, input int subj, input bit known,
                               input int skip);
        for (int i = 0; i < NSLOTS; i++)
            if (tbl_used[i] && i != skip) add_notice(kind, i, subj, known);
    endtask

    // Apply one accepted request to the table and queue the notices it must produce.
    task automatic apply_session_event(input request_t req);
        int      hit;
        int      free_slot;
        notice_t n;
        hit       = -1;
        free_slot = -1;
        // Match on stored address and stored port; the lowest slot wins.
        for (int i = 0; i < NSLOTS; i++)
            if (hit < 0 && tbl_used[i] && tbl_ip[i] == req.ip && tbl_port[i] == req.sport)
                hit = i;
        case (req.mode)
            MODE_TICK: begin
                // Age in ascending order; a slot freed here is already gone for later slots.
                for (int i = 0; i < NSLOTS; i++) begin
                    if (tbl_used[i]) begin
                        if (tbl_timer[i] == '0) begin
                            notify_used(KIND_QUIT, i, 1'b1, i);
                            tbl_used[i] = 1'b0;
                        end else begin
                            tbl_timer[i] = tbl_timer[i] - 1'b1;
                        end
                    end
                end
            end
            MODE_JOIN: begin
                if (hit >= 0) begin
                    tbl_timer[hit] = timeout_shadow;
                end else begin
                    for (int i = NSLOTS - 1; i >= 0; i--)
                        if (!tbl_used[i]) free_slot = i;
                    // A full table drops the join without a word.
                    if (free_slot >= 0) begin
                        tbl_used[free_slot]  = 1'b1;
                        tbl_ip[free_slot]    = req.ip;
                        tbl_port[free_slot]  = req.jport;
                        tbl_timer[free_slot] = timeout_shadow;
                        for (int i = 0; i < NSLOTS; i++)
                            if (tbl_used[i]) add_notice(KIND_USER, free_slot, i, 1'b1);
                        notify_used(KIND_JOIN, free_slot, 1'b1, free_slot);
                    end
                end
            end
            MODE_QUIT: begin
                if (hit >= 0) begin
                    notify_used(KIND_QUIT, hit, 1'b1, hit);
                    tbl_used[hit] = 1'b0;
                end
            end
            MODE_CHAT: begin
                // Unknown senders still reach everyone, just without a subject.
                if (hit >= 0) notify_used(KIND_CHAT, hit, 1'b1, -1);
                else          notify_used(KIND_CHAT, 0, 1'b0, -1);
            end
            default: ;
        endcase
        // Flag the final notice of the burst and hand the burst over.
        for (int i = 0; i < burst.size(); i++) begin
            n      = burst[i];
            n.last = (i == burst.size() - 1);
            notices_q.push_back(n);
        end
        burst.delete();
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // ---------------------------------------------------------------- driver

    // Present the next request once the previous one is taken; idle at random.
    always @(posedge aclk) begin : drive_requests
        request_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.jport, nxt.sport, nxt.ip};
                s_axis_tuser  <= nxt.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Predict on every accepted request, then check every accepted notice; stall at random.
    always @(posedge aclk) begin : observe_notices
        request_t req;
        notice_t  want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                req.mode  = s_axis_tuser;
                req.ip    = s_axis_tdata[31:0];
                req.sport = s_axis_tdata[47:32];
                req.jport = s_axis_tdata[63:48];
                apply_session_event(req);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (notices_q.size() == 0) begin
                    $display("%0t: unexpected notice: expected none, got tdata %0h tuser %0h",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = notices_q.pop_front();
                    check_field("kind", 32'(want.body.kind), 32'(m_axis_tuser[1:0]));
                    check_field("dest_slot", 32'(want.body.dest_slot), 32'(m_axis_tdata[2:0]));
                    check_field("dest_ip", want.body.dest_ip, m_axis_tdata[34:3]);
                    check_field("dest_port", 32'(want.body.dest_port), 32'(m_axis_tdata[50:35]));
                    check_field("subject_slot", 32'(want.body.subject_slot),
                                32'(m_axis_tdata[53:51]));
                    check_field("subject_known", 32'(want.body.subject_known),
                                32'(m_axis_tuser[2]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ---------------------------------------------------------------- sequencing

    task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [IP_W-1:0] ip,
                                 input logic [PORT_W-1:0] sport, input logic [PORT_W-1:0] jport);
        request_t r;
        r.mode  = mode;
        r.ip    = ip;
        r.sport = sport;
        r.jport = jport;
        request_q.push_back(r);
    endtask

    // Hold until every request is taken and every notice has come, then let the block settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_axis_tvalid || notices_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write timeout_ticks; call only while the block is idle.
    task automatic set_timeout(input logic [TIMER_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        timeout_shadow  = value;
        @(negedge aclk);
    endtask

    // Mostly well-behaved peers that join, chat, stay and quit; some strangers and junk modes.
    task automatic queue_random(input int count);
        int                p;
        int                roll;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        for (int k = 0; k < count; k++) begin
            p    = $urandom_range(NPEERS - 1);
            ip   = peer_ip[p];
            port = peer_port[p];
            if ($urandom_range(9) == 0) begin
                ip   = $urandom;
                port = 16'($urandom);
            end
            roll = $urandom_range(99);
            if (roll < 34)
                queue_request(MODE_JOIN, ip, port,
                              ($urandom_range(9) == 0) ? 16'($urandom) : port);
            else if (roll < 58)
                queue_request(MODE_TICK, $urandom, 16'($urandom), 16'($urandom));
            else if (roll < 72)
                queue_request(MODE_QUIT, ip, port, 16'($urandom));
            else if (roll < 95)
                queue_request(MODE_CHAT, ip, port, 16'($urandom));
            else
                queue_request(MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)), ip, port,
                              16'($urandom));
        end
    endtask

    initial begin : run_sequence
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        errors         = 0;
        timeout_shadow = TIMEOUT_RESET;
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_ip[i]    = '0;
            tbl_port[i]  = '0;
            tbl_timer[i] = '0;
        end
        // Two peers at the field extremes, the rest random.
        peer_ip[0]   = '0;
        peer_port[0] = '0;
        peer_ip[1]   = '1;
        peer_port[1] = '1;
        for (int i = 2; i < NPEERS; i++) begin
            peer_ip[i]   = $urandom;
            peer_port[i] = 16'($urandom);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table first, nothing may come out.
        queue_request(MODE_TICK, '1, '1, '1);
        queue_request(MODE_QUIT, peer_ip[1], peer_port[1], '0);
        queue_request(MODE_CHAT, peer_ip[0], peer_port[0], '1);
        // Join with a source port other than the announced one; the announced one is stored.
        queue_request(MODE_JOIN, peer_ip[0], '1, peer_port[0]);
        queue_request(MODE_JOIN, peer_ip[1], '0, peer_port[1]);
        // Stay: matches on the stored port, emits nothing.
        queue_request(MODE_JOIN, peer_ip[0], peer_port[0], 16'h1234);
        queue_request(MODE_CHAT, peer_ip[1], peer_port[1], '0);
        // Chat from a sender that is not in the table.
        queue_request(MODE_CHAT, peer_ip[0], 16'h0001, '0);
        // Unused modes are dropped.
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
            queue_request(MODE_W'(m), '1, '1, '1);
        // Fill the table, then knock on a full one.
        for (int i = 2; i < NSLOTS; i++)
            queue_request(MODE_JOIN, peer_ip[i], peer_port[i], peer_port[i]);
        queue_request(MODE_JOIN, peer_ip[NSLOTS], peer_port[NSLOTS], peer_port[NSLOTS]);
        // Free slot 1 and let the rejected peer take the lowest free slot.
        queue_request(MODE_QUIT, peer_ip[1], peer_port[1], '0);
        queue_request(MODE_JOIN, peer_ip[NSLOTS], peer_port[NSLOTS], peer_port[NSLOTS]);
        wait_idle();

        // Directed: zero timeout, two slots expiring in the same tick.
        set_timeout('0);
        queue_request(MODE_JOIN, peer_ip[2], peer_port[2], peer_port[2]);
        queue_request(MODE_JOIN, peer_ip[3], peer_port[3], peer_port[3]);
        queue_request(MODE_TICK, '0, '0, '0);
        wait_idle();

        // Random phases, each with its own timeout and idling pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_timeout(phase_timeout[ph]);
            src_idle_pct = phase_src_idle[ph];
            snk_idle_pct = phase_snk_idle[ph];
            queue_random(PHASE_REQUESTS / 2);
            wait_idle();
            queue_random(PHASE_REQUESTS - PHASE_REQUESTS / 2);
            wait_idle();
        end

        if (errors == 0 && notices_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
